FILE: hdl/hfpp_pkg.sv
// Package for the hex field packet parser.
// Holds the body layout constants and the character class helpers.
// No dependencies.
`default_nettype none

package hfpp_pkg;

    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] BODY_LEN = 4'd13;

    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_E = 8'h45;

    localparam logic [4:0] HEX_NONE   = 5'd16;
    localparam logic [4:0] MOOD_MAX   = 5'd4;
    localparam logic [4:0] DIGIT2_MAX = 5'd3;

    // body character positions
    localparam logic [POS_W-1:0] P_F0    = 4'd0;
    localparam logic [POS_W-1:0] P_ONE   = 4'd1;
    localparam logic [POS_W-1:0] P_M     = 4'd2;
    localparam logic [POS_W-1:0] P_MOOD  = 4'd3;
    localparam logic [POS_W-1:0] P_F1    = 4'd4;
    localparam logic [POS_W-1:0] P_FACTH = 4'd5;
    localparam logic [POS_W-1:0] P_FACTL = 4'd6;
    localparam logic [POS_W-1:0] P_S     = 4'd7;
    localparam logic [POS_W-1:0] P_STYLE = 4'd8;
    localparam logic [POS_W-1:0] P_G     = 4'd9;
    localparam logic [POS_W-1:0] P_GEST  = 4'd10;
    localparam logic [POS_W-1:0] P_E     = 4'd11;
    localparam logic [POS_W-1:0] P_INT   = 4'd12;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // hex digit value, HEX_NONE for a non-digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hex_field_packet_parser_unit.sv
// Hex field packet parser, top level.
// Depends on hfpp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one character per item in
//   char_code, with end_of_packet high on the last character of a packet.
//   Output channel (out_valid/out_ready) carries one result item per packet:
//   packet_valid and the decoded mood, fact_id, style, gesture, intensity.
//   Fields are all zero when the packet is invalid.
//   Leading and trailing whitespace is trimmed; the body must read
//   F1MxFxxSxGxEx with hex digits in either case.
//   Latency: the result appears on out_valid the cycle after the last
//   character is accepted. Throughput: one character per cycle while
//   in_ready is high; the parse state and the checks for one character
//   sit between the input handshake and the parse/result registers.
//   Stall: in_ready = !out_valid || out_ready, so characters keep flowing
//   while no result is pending; a held result blocks input until taken.
//   Reset: parse state cleared, no result pending. After each packet the
//   parse state returns to its reset value.
`default_nettype none

module hex_field_packet_parser_unit
    import hfpp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_packet,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            packet_valid,
    output logic [2:0]      mood,
    output logic [7:0]      fact_id,
    output logic [1:0]      style,
    output logic [1:0]      gesture,
    output logic [1:0]      intensity
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             started_reg, started_next;
    logic             trail_reg, trail_next;
    logic             err_reg, err_next;
    logic [2:0]       mood_reg, mood_next;
    logic [7:0]       fact_reg, fact_next;
    logic [1:0]       style_reg, style_next;
    logic [1:0]       gest_reg, gest_next;
    logic [1:0]       int_reg, int_next;

    logic             out_valid_reg;
    logic             pkt_ok_reg;
    logic [2:0]       out_mood_reg;
    logic [7:0]       out_fact_reg;
    logic [1:0]       out_style_reg;
    logic [1:0]       out_gest_reg;
    logic [1:0]       out_int_reg;

    logic             accept;
    logic             blank;
    logic             take;
    logic             match;
    logic [4:0]       digit;
    logic             ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign blank    = is_blank(char_code);
    assign digit    = hex_value(char_code);
    assign take     = !blank && !trail_reg && (pos_reg < BODY_LEN);

    always_comb
    begin
        mood_next  = mood_reg;
        fact_next  = fact_reg;
        style_next = style_reg;
        gest_next  = gest_reg;
        int_next   = int_reg;
        match      = 1'b0;
        unique case (pos_reg)
            P_F0, P_F1: match = (char_code == CH_F);
            P_ONE:      match = (char_code == CH_1);
            P_M:        match = (char_code == CH_M);
            P_S:        match = (char_code == CH_S);
            P_G:        match = (char_code == CH_G);
            P_E:        match = (char_code == CH_E);
            P_MOOD:
            begin
                match     = (digit <= MOOD_MAX);
                mood_next = digit[2:0];
            end
            P_FACTH:
            begin
                match     = (digit < HEX_NONE);
                fact_next = {digit[3:0], 4'h0};
            end
            P_FACTL:
            begin
                match     = (digit < HEX_NONE);
                fact_next = {fact_reg[7:4], digit[3:0]};
            end
            P_STYLE:
            begin
                match      = (digit <= DIGIT2_MAX);
                style_next = digit[1:0];
            end
            P_GEST:
            begin
                match     = (digit <= DIGIT2_MAX);
                gest_next = digit[1:0];
            end
            P_INT:
            begin
                match    = (digit <= DIGIT2_MAX);
                int_next = digit[1:0];
            end
            default:    match = 1'b0;
        endcase
        if (!take)
        begin
            mood_next  = mood_reg;
            fact_next  = fact_reg;
            style_next = style_reg;
            gest_next  = gest_reg;
            int_next   = int_reg;
        end
    end

    always_comb
    begin
        started_next = started_reg || !blank;
        trail_next   = trail_reg || (blank && started_reg);
        err_next     = err_reg || (!blank && !take) || (take && !match);
        pos_next     = take ? pos_reg + 4'd1 : pos_reg;
    end

    assign ok = started_next && !err_next && (pos_next == BODY_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            started_reg <= 1'b0;
            trail_reg   <= 1'b0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_packet)
            begin
                pos_reg     <= '0;
                started_reg <= 1'b0;
                trail_reg   <= 1'b0;
                err_reg     <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                started_reg <= started_next;
                trail_reg   <= trail_next;
                err_reg     <= err_next;
            end
        end
    end

    // field holds are only read after a successful parse of the same packet
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mood_reg  <= mood_next;
            fact_reg  <= fact_next;
            style_reg <= style_next;
            gest_reg  <= gest_next;
            int_reg   <= int_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && end_of_packet)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_packet)
        begin
            pkt_ok_reg    <= ok;
            out_mood_reg  <= ok ? mood_next  : '0;
            out_fact_reg  <= ok ? fact_next  : '0;
            out_style_reg <= ok ? style_next : '0;
            out_gest_reg  <= ok ? gest_next  : '0;
            out_int_reg   <= ok ? int_next   : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packet_valid = pkt_ok_reg;
    assign mood         = out_mood_reg;
    assign fact_id      = out_fact_reg;
    assign style        = out_style_reg;
    assign gesture      = out_gest_reg;
    assign intensity    = out_int_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= BODY_LEN)
        else $error("body position beyond body length");

    a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_packet |=> pos_reg == '0 && !started_reg && !trail_reg && !err_reg)
        else $error("parse state not cleared after packet end");

    a_eop_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_packet |=> out_valid)
        else $error("no result after packet end");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !packet_valid |-> mood == '0 && fact_id == '0 && style == '0
            && gesture == '0 && intensity == '0)
        else $error("invalid packet with nonzero fields");

    a_mood_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_valid |-> mood <= 3'd4)
        else $error("mood out of range");
`endif

endmodule

`default_nettype wire
